### hdl/pflu_pkg.sv
// Shared types and constants of the polygon face lighting unit.
// No dependencies; used by pflu_fmul, pflu_fadd and the top level.
package pflu_pkg;

  // Operand class after unpacking; decides the special-case result.
  typedef enum logic [1:0] {
    FC_NUM  = 2'd0,
    FC_ZERO = 2'd1,
    FC_INF  = 2'd2,
    FC_NAN  = 2'd3
  } fclass_e;

  // Register index, byte address bits [3:2].
  typedef enum logic [1:0] {
    REG_LIGHT_X = 2'd0,
    REG_LIGHT_Y = 2'd1,
    REG_LIGHT_Z = 2'd2,
    REG_SPEC    = 2'd3
  } reg_idx_e;

  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] FP_TWO      = 32'h4000_0000;
  localparam logic [31:0] FP_POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] LIGHT_Z_RST = 32'h3F80_0000;

  function automatic logic fp_is_nan(logic [31:0] v);
    fp_is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // True when the value compares below zero (not NaN, not a zero).
  function automatic logic fp_is_neg(logic [31:0] v);
    fp_is_neg = v[31] && !fp_is_nan(v) && (v[30:0] != 31'd0);
  endfunction

endpackage

### hdl/pflu_fmul.sv
// Three-stage IEEE single multiplier, round to nearest even, subnormals kept.
// Depends on pflu_pkg. Carries a sideband word with the same latency.
module pflu_fmul #(
  parameter int SW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          v_i,
  input  logic [31:0]   a_i,
  input  logic [31:0]   b_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [31:0]   y_o,
  output logic [SW-1:0] side_o
);
  import pflu_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic [SW-1:0] sd1_q, sd2_q, sd3_q;

  // stage 1: unpack and mantissa product
  logic              sg1_q;
  fclass_e           c1_q;
  logic signed [10:0] e1_q;
  logic [47:0]       p1_q;
  logic              sg1_d;
  fclass_e           c1_d;
  logic signed [10:0] e1_d;
  logic [47:0]       p1_d;

  always_comb begin
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic na, nb, ia, ib, za, zb;
    ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb = {b_i[30:23] != 8'd0, b_i[22:0]};
    na = fp_is_nan(a_i);
    nb = fp_is_nan(b_i);
    ia = (a_i[30:0] == 31'h7F80_0000);
    ib = (b_i[30:0] == 31'h7F80_0000);
    za = (a_i[30:0] == 31'd0);
    zb = (b_i[30:0] == 31'd0);
    sg1_d = a_i[31] ^ b_i[31];
    if (na || nb || (ia && zb) || (za && ib)) begin
      c1_d = FC_NAN;
    end else if (ia || ib) begin
      c1_d = FC_INF;
    end else if (za || zb) begin
      c1_d = FC_ZERO;
    end else begin
      c1_d = FC_NUM;
    end
    e1_d = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
    p1_d = ma * mb;
  end

  // stage 2: leading-zero count and normalize
  logic              sg2_q;
  fclass_e           c2_q;
  logic signed [10:0] e2_q;
  logic [47:0]       n2_q;
  logic signed [10:0] e2_d;
  logic [47:0]       n2_d;

  always_comb begin
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p1_q[i]) begin
        lz = 6'(47 - i);
      end
    end
    n2_d = p1_q << lz;
    e2_d = e1_q - $signed({5'd0, lz});
  end

  // stage 3: denormalize on underflow, round, pack
  logic [31:0] y3_d, y3_q;

  always_comb begin
    logic [10:0] sh_raw;
    logic [6:0]  sh;
    logic [95:0] wide;
    logic [47:0] nn;
    logic        lost, g, st, inc;
    logic [23:0] mant;
    logic [7:0]  ef;
    logic [30:0] mag;
    sh_raw = 11'(11'sd1 - e2_q);
    if (e2_q >= 11'sd1) begin
      sh = 7'd0;
    end else if (sh_raw > 11'd49) begin
      sh = 7'd49;
    end else begin
      sh = sh_raw[6:0];
    end
    wide = {n2_q, 48'd0} >> sh;
    nn   = wide[95:48];
    lost = |wide[47:0];
    mant = nn[47:24];
    g    = nn[23];
    st   = (|nn[22:0]) | lost;
    inc  = g & (st | mant[0]);
    ef   = (e2_q >= 11'sd1) ? e2_q[7:0] : 8'd0;
    mag  = {ef, mant[22:0]} + 31'(inc);
    case (c2_q)
      FC_NAN:  y3_d = FP_QNAN;
      FC_INF:  y3_d = {sg2_q, 8'hFF, 23'd0};
      FC_ZERO: y3_d = {sg2_q, 31'd0};
      default: begin
        if (e2_q >= 11'sd255) begin
          y3_d = {sg2_q, 8'hFF, 23'd0};
        end else begin
          y3_d = {sg2_q, mag};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sg1_q <= sg1_d;
      c1_q  <= c1_d;
      e1_q  <= e1_d;
      p1_q  <= p1_d;
      sd1_q <= side_i;
      sg2_q <= sg1_q;
      c2_q  <= c1_q;
      e2_q  <= e2_d;
      n2_q  <= n2_d;
      sd2_q <= sd1_q;
      y3_q  <= y3_d;
      sd3_q <= sd2_q;
    end
  end

  assign v_o    = v3_q;
  assign y_o    = y3_q;
  assign side_o = sd3_q;

endmodule

### hdl/pflu_fadd.sv
// Three-stage IEEE single adder, round to nearest even, subnormals kept.
// Depends on pflu_pkg. Carries a sideband word with the same latency.
module pflu_fadd #(
  parameter int SW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          v_i,
  input  logic [31:0]   a_i,
  input  logic [31:0]   b_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [31:0]   y_o,
  output logic [SW-1:0] side_o
);
  import pflu_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic [SW-1:0] sd1_q, sd2_q, sd3_q;

  // stage 1: order by magnitude, align the smaller operand
  logic        sg1_q, sub1_q;
  fclass_e     c1_q;
  logic [7:0]  e1_q;
  logic [26:0] mx1_q, my1_q;
  logic        sg1_d, sub1_d;
  fclass_e     c1_d;
  logic [7:0]  e1_d;
  logic [26:0] mx1_d, my1_d;

  always_comb begin
    logic [31:0] x, y;
    logic [7:0]  ey, d;
    logic [5:0]  sh;
    logic [53:0] wide;
    logic        nx, ny, ix, iy;
    if (b_i[30:0] > a_i[30:0]) begin
      x = b_i;
      y = a_i;
    end else begin
      x = a_i;
      y = b_i;
    end
    nx = fp_is_nan(x);
    ny = fp_is_nan(y);
    ix = (x[30:0] == 31'h7F80_0000);
    iy = (y[30:0] == 31'h7F80_0000);
    sub1_d = x[31] ^ y[31];
    sg1_d  = x[31];
    if (nx || ny || (ix && iy && sub1_d)) begin
      c1_d = FC_NAN;
    end else if (ix) begin
      c1_d = FC_INF;
    end else begin
      c1_d = FC_NUM;
    end
    e1_d  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d     = e1_d - ey;
    sh    = (d > 8'd28) ? 6'd28 : d[5:0];
    mx1_d = {x[30:23] != 8'd0, x[22:0], 3'b000};
    wide  = {y[30:23] != 8'd0, y[22:0], 3'b000, 27'd0} >> sh;
    my1_d = {wide[53:28], wide[27] | (|wide[26:0])};
  end

  // stage 2: magnitude add or subtract
  logic        sg2_q, sub2_q;
  fclass_e     c2_q;
  logic [7:0]  e2_q;
  logic [27:0] s2_q, s2_d;

  always_comb begin
    if (sub1_q) begin
      s2_d = {1'b0, mx1_q} - {1'b0, my1_q};
    end else begin
      s2_d = {1'b0, mx1_q} + {1'b0, my1_q};
    end
  end

  // stage 3: normalize, round, pack
  logic [31:0] y3_d, y3_q;

  always_comb begin
    logic [26:0] n;
    logic [8:0]  e;
    logic [4:0]  lz, shl;
    logic [7:0]  lim, ef;
    logic [23:0] mant;
    logic        g, st, inc, sg;
    logic [30:0] mag;
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (s2_q[i]) begin
        lz = 5'(26 - i);
      end
    end
    lim = e2_q - 8'd1;
    if (s2_q[27]) begin
      shl = 5'd0;
      n   = {s2_q[27:2], s2_q[1] | s2_q[0]};
      e   = {1'b0, e2_q} + 9'd1;
    end else begin
      shl = ({3'd0, lz} < lim) ? lz : lim[4:0];
      n   = s2_q[26:0] << shl;
      e   = {1'b0, e2_q} - {4'd0, shl};
    end
    mant = n[26:3];
    g    = n[2];
    st   = n[1] | n[0];
    inc  = g & (st | mant[0]);
    ef   = n[26] ? e[7:0] : 8'd0;
    mag  = {ef, mant[22:0]} + 31'(inc);
    sg   = (s2_q == 28'd0 && sub2_q) ? 1'b0 : sg2_q;
    case (c2_q)
      FC_NAN: y3_d = FP_QNAN;
      FC_INF: y3_d = {sg2_q, 8'hFF, 23'd0};
      default: begin
        if (e >= 9'd255) begin
          y3_d = {sg, 8'hFF, 23'd0};
        end else begin
          y3_d = {sg, mag};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sg1_q  <= sg1_d;
      sub1_q <= sub1_d;
      c1_q   <= c1_d;
      e1_q   <= e1_d;
      mx1_q  <= mx1_d;
      my1_q  <= my1_d;
      sd1_q  <= side_i;
      sg2_q  <= sg1_q;
      sub2_q <= sub1_q;
      c2_q   <= c1_q;
      e2_q   <= e1_q;
      s2_q   <= s2_d;
      sd2_q  <= sd1_q;
      y3_q   <= y3_d;
      sd3_q  <= sd2_q;
    end
  end

  assign v_o    = v3_q;
  assign y_o    = y3_q;
  assign side_o = sd3_q;

endmodule

### hdl/polygon_face_lighting_luma_unit.sv
// Polygon face lighting: luminance and facing flag per polygon, IEEE single math.
// Depends on pflu_pkg, pflu_fmul and pflu_fadd.
//
// One polygon transfer is taken on every clock while the result side keeps up;
// each polygon passes through eleven float operation levels
// of three stages each, plus the output register. The whole chain moves on one
// advance enable: it halts only while a finished result waits unclaimed, so
// nothing is lost or repeated. Levels: six products for the two dot products,
// two partial sums, the final dot sums, the sign-test product with 2*dotl, the
// diffuse product with the specular base, the ambient add with the light_z
// subtract, three optional squarings, the specular scale, and the final add.
// Registers (APB, byte address 4*index): light_x, light_y, light_z (float bits)
// and specular_mode (bit 0); write them only while no polygon is in flight.
module polygon_face_lighting_luma_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // normal_x, normal_y, normal_z, point_x, point_y, point_z, diffuse, ambient
  // (32 each), spec exponent control (3), spec gain (32), zero pad (5)
  input  logic [295:0]           s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // luma (8), front (1), zero pad (7)
  output logic [15:0]            m_axis_tdata
);
  import pflu_pkg::*;

  // ---------------- configuration registers ----------------
  logic [31:0] light_x_q, light_y_q, light_z_q;
  logic        spec_mode_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q   <= 32'd0;
      light_y_q   <= 32'd0;
      light_z_q   <= LIGHT_Z_RST;
      spec_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LIGHT_X: light_x_q   <= pwdata;
        REG_LIGHT_Y: light_y_q   <= pwdata;
        REG_LIGHT_Z: light_z_q   <= pwdata;
        REG_SPEC:    spec_mode_q <= pwdata[0];
        default:     spec_mode_q <= spec_mode_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LIGHT_X: prdata = light_x_q;
      REG_LIGHT_Y: prdata = light_y_q;
      REG_LIGHT_Z: prdata = light_z_q;
      REG_SPEC:    prdata = {31'd0, spec_mode_q};
      default:     prdata = 32'd0;
    endcase
  end

  // ---------------- stall control ----------------
  // Everything advances together unless the output register holds a result
  // that the sink has not taken yet.
  logic        adv;
  logic        out_valid_q;
  logic [7:0]  luma_q;
  logic        front_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // input field unpack
  logic [31:0] in_nx, in_ny, in_nz, in_px, in_py, in_pz, in_dif, in_amb, in_ssc;
  logic [2:0]  in_ctl;
  assign in_nx  = s_axis_tdata[31:0];
  assign in_ny  = s_axis_tdata[63:32];
  assign in_nz  = s_axis_tdata[95:64];
  assign in_px  = s_axis_tdata[127:96];
  assign in_py  = s_axis_tdata[159:128];
  assign in_pz  = s_axis_tdata[191:160];
  assign in_dif = s_axis_tdata[223:192];
  assign in_amb = s_axis_tdata[255:224];
  assign in_ctl = s_axis_tdata[258:256];
  assign in_ssc = s_axis_tdata[290:259];

  // ---------------- level 1: six products ----------------
  logic [5:0]  l1_v;
  logic [31:0] l1_pl0, l1_pl1, l1_pl2, l1_pp0, l1_pp1, l1_pp2;
  logic [31:0] l1_nz, l1_dif, l1_amb;
  logic [15:0] l1_ssc_hi, l1_ssc_lo;
  logic [2:0]  l1_ctl;

  pflu_fmul #(.SW(32)) u_l1_m0 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(s_axis_tvalid), .a_i(in_nx), .b_i(light_x_q),
    .side_i(in_nz), .v_o(l1_v[0]), .y_o(l1_pl0), .side_o(l1_nz));
  pflu_fmul #(.SW(32)) u_l1_m1 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(s_axis_tvalid), .a_i(in_ny), .b_i(light_y_q),
    .side_i(in_dif), .v_o(l1_v[1]), .y_o(l1_pl1), .side_o(l1_dif));
  pflu_fmul #(.SW(32)) u_l1_m2 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(s_axis_tvalid), .a_i(in_nz), .b_i(light_z_q),
    .side_i(in_amb), .v_o(l1_v[2]), .y_o(l1_pl2), .side_o(l1_amb));
  pflu_fmul #(.SW(16)) u_l1_m3 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(s_axis_tvalid), .a_i(in_nx), .b_i(in_px),
    .side_i(in_ssc[31:16]), .v_o(l1_v[3]), .y_o(l1_pp0), .side_o(l1_ssc_hi));
  pflu_fmul #(.SW(16)) u_l1_m4 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(s_axis_tvalid), .a_i(in_ny), .b_i(in_py),
    .side_i(in_ssc[15:0]), .v_o(l1_v[4]), .y_o(l1_pp1), .side_o(l1_ssc_lo));
  pflu_fmul #(.SW(3)) u_l1_m5 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(s_axis_tvalid), .a_i(in_nz), .b_i(in_pz),
    .side_i(in_ctl), .v_o(l1_v[5]), .y_o(l1_pp2), .side_o(l1_ctl));

  // ---------------- level 2: x + y partial sums ----------------
  logic [1:0]  l2_v;
  logic [31:0] l2_sl, l2_sp, l2_pl2, l2_pp2, l2_nz, l2_dif, l2_amb, l2_ssc;
  logic [2:0]  l2_ctl;

  pflu_fadd #(.SW(67)) u_l2_a0 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l1_v), .a_i(l1_pl0), .b_i(l1_pl1),
    .side_i({l1_pl2, l1_nz, l1_ctl}), .v_o(l2_v[0]), .y_o(l2_sl),
    .side_o({l2_pl2, l2_nz, l2_ctl}));
  pflu_fadd #(.SW(128)) u_l2_a1 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l1_v), .a_i(l1_pp0), .b_i(l1_pp1),
    .side_i({l1_pp2, l1_dif, l1_amb, l1_ssc_hi, l1_ssc_lo}), .v_o(l2_v[1]),
    .y_o(l2_sp), .side_o({l2_pp2, l2_dif, l2_amb, l2_ssc}));

  // ---------------- level 3: dot sums ----------------
  logic [1:0]  l3_v;
  logic [31:0] l3_dotl, l3_dotp, l3_nz, l3_dif, l3_amb, l3_ssc;
  logic [2:0]  l3_ctl;

  pflu_fadd #(.SW(35)) u_l3_a0 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l2_v), .a_i(l2_sl), .b_i(l2_pl2),
    .side_i({l2_nz, l2_ctl}), .v_o(l3_v[0]), .y_o(l3_dotl), .side_o({l3_nz, l3_ctl}));
  pflu_fadd #(.SW(96)) u_l3_a1 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l2_v), .a_i(l2_sp), .b_i(l2_pp2),
    .side_i({l2_dif, l2_amb, l2_ssc}), .v_o(l3_v[1]), .y_o(l3_dotp),
    .side_o({l3_dif, l3_amb, l3_ssc}));

  // ---------------- level 4: sign test and 2*dotl ----------------
  logic        l3_front;
  logic [1:0]  l4_v;
  logic [31:0] l4_st, l4_twol, l4_dotl, l4_nz, l4_dif, l4_amb, l4_ssc;
  logic [2:0]  l4_ctl;
  logic        l4_front;

  // facing: dotp >= 0, false for NaN
  assign l3_front = !fp_is_nan(l3_dotp) && (!l3_dotp[31] || l3_dotp[30:0] == 31'd0);

  pflu_fmul #(.SW(65)) u_l4_m0 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l3_v), .a_i(l3_dotl), .b_i(l3_dotp),
    .side_i({l3_front, l3_dotl, l3_nz}), .v_o(l4_v[0]), .y_o(l4_st),
    .side_o({l4_front, l4_dotl, l4_nz}));
  pflu_fmul #(.SW(99)) u_l4_m1 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l3_v), .a_i(l3_dotl), .b_i(FP_TWO),
    .side_i({l3_dif, l3_amb, l3_ctl, l3_ssc}), .v_o(l4_v[1]), .y_o(l4_twol),
    .side_o({l4_dif, l4_amb, l4_ctl, l4_ssc}));

  // ---------------- level 5: diffuse product, specular base ----------------
  logic [31:0] l4_lum;
  logic [1:0]  l5_v;
  logic [31:0] l5_t, l5_sp, l5_amb, l5_ssc;
  logic [2:0]  l5_ctl;
  logic        l5_front;

  // opposite signs of dotl and dotp kill the diffuse term, else |dotl|
  assign l4_lum = fp_is_neg(l4_st) ? FP_POS_ZERO : {1'b0, l4_dotl[30:0]};

  pflu_fmul #(.SW(33)) u_l5_m0 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l4_v), .a_i(l4_lum), .b_i(l4_dif),
    .side_i({l4_front, l4_amb}), .v_o(l5_v[0]), .y_o(l5_t), .side_o({l5_front, l5_amb}));
  pflu_fmul #(.SW(35)) u_l5_m1 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l4_v), .a_i(l4_twol), .b_i(l4_nz),
    .side_i({l4_ctl, l4_ssc}), .v_o(l5_v[1]), .y_o(l5_sp), .side_o({l5_ctl, l5_ssc}));

  // ---------------- level 6: ambient add, minus light_z ----------------
  logic [1:0]  l6_v;
  logic [31:0] l6_lum, l6_s, l6_ssc;
  logic [2:0]  l6_ctl;
  logic        l6_front;

  pflu_fadd #(.SW(1)) u_l6_a0 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l5_v), .a_i(l5_t), .b_i(l5_amb),
    .side_i(l5_front), .v_o(l6_v[0]), .y_o(l6_lum), .side_o(l6_front));
  pflu_fadd #(.SW(35)) u_l6_a1 (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l5_v), .a_i(l5_sp),
    .b_i({~light_z_q[31], light_z_q[30:0]}),
    .side_i({l5_ctl, l5_ssc}), .v_o(l6_v[1]), .y_o(l6_s), .side_o({l6_ctl, l6_ssc}));

  // ---------------- levels 7..9: optional squarings ----------------
  // A skipped squaring multiplies by one, which leaves the value unchanged.
  logic [31:0] l6_sc;
  logic        l7_v, l8_v, l9_v;
  logic [31:0] l7_s, l8_s, l9_s;
  logic [31:0] l7_lum, l8_lum, l9_lum, l7_ssc, l8_ssc, l9_ssc;
  logic [2:0]  l7_ctl, l8_ctl, l9_ctl;
  logic        l7_front, l8_front, l9_front;

  assign l6_sc = (fp_is_neg(l6_s) || l6_ctl == 3'd0) ? FP_POS_ZERO : l6_s;

  pflu_fmul #(.SW(68)) u_l7_m (
    .clk_i, .rst_ni, .en_i(adv), .v_i(&l6_v), .a_i(l6_sc),
    .b_i((l6_ctl >= 3'd2) ? l6_sc : FP_ONE),
    .side_i({l6_front, l6_lum, l6_ctl, l6_ssc}), .v_o(l7_v), .y_o(l7_s),
    .side_o({l7_front, l7_lum, l7_ctl, l7_ssc}));
  pflu_fmul #(.SW(68)) u_l8_m (
    .clk_i, .rst_ni, .en_i(adv), .v_i(l7_v), .a_i(l7_s),
    .b_i((l7_ctl >= 3'd4) ? l7_s : FP_ONE),
    .side_i({l7_front, l7_lum, l7_ctl, l7_ssc}), .v_o(l8_v), .y_o(l8_s),
    .side_o({l8_front, l8_lum, l8_ctl, l8_ssc}));
  pflu_fmul #(.SW(68)) u_l9_m (
    .clk_i, .rst_ni, .en_i(adv), .v_i(l8_v), .a_i(l8_s),
    .b_i((l8_ctl == 3'd7) ? l8_s : FP_ONE),
    .side_i({l8_front, l8_lum, l8_ctl, l8_ssc}), .v_o(l9_v), .y_o(l9_s),
    .side_o({l9_front, l9_lum, l9_ctl, l9_ssc}));

  // ---------------- level 10: specular scale ----------------
  logic        l10_v;
  logic [31:0] l10_spec, l10_lum;
  logic        l10_front;

  pflu_fmul #(.SW(33)) u_l10_m (
    .clk_i, .rst_ni, .en_i(adv), .v_i(l9_v), .a_i(l9_s), .b_i(l9_ssc),
    .side_i({l9_front, l9_lum}), .v_o(l10_v), .y_o(l10_spec),
    .side_o({l10_front, l10_lum}));

  // ---------------- level 11: final add ----------------
  // Without specular mode the addend is -0, an exact identity.
  logic        l11_v;
  logic [31:0] l11_lum;
  logic        l11_front;

  pflu_fadd #(.SW(1)) u_l11_a (
    .clk_i, .rst_ni, .en_i(adv), .v_i(l10_v), .a_i(l10_lum),
    .b_i(spec_mode_q ? l10_spec : FP_NEG_ZERO),
    .side_i(l10_front), .v_o(l11_v), .y_o(l11_lum), .side_o(l11_front));

  // ---------------- clamp, truncate, output register ----------------
  logic [7:0]  luma_d;
  logic [23:0] mant_sh;

  always_comb begin
    mant_sh = {1'b1, l11_lum[22:0]} >> (8'd150 - l11_lum[30:23]);
    if (fp_is_nan(l11_lum) || l11_lum[31]) begin
      luma_d = 8'd0;
    end else if (l11_lum[30:23] >= 8'd135) begin
      luma_d = 8'd255;
    end else if (l11_lum[30:23] < 8'd127) begin
      luma_d = 8'd0;
    end else begin
      luma_d = mant_sh[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= l11_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      luma_q  <= luma_d;
      front_q <= l11_front;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, front_q, luma_q};

  // ---------------- assertions ----------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");

  a_hold_pipe_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(l11_v) && $stable(l11_lum) && $stable(l10_v))
    else $error("pipeline moved during a stall");

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && cfg_idx == REG_SPEC |=> spec_mode_q == $past(pwdata[0]))
    else $error("specular mode write lost");

endmodule
